// ----- rtl/core/assert_macros.svh -----
// assert_macros.svh: concurrent assertion macros for the dilation core RTL.
// No dependencies; the using module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define BDIL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
// Check that a condition never holds.
`define BDIL_ASSERT_NEVER(label, expr) \
  `BDIL_ASSERT(label, !(expr))
`else
`define BDIL_ASSERT(label, prop)
`define BDIL_ASSERT_NEVER(label, expr)
`endif
`endif

// ----- rtl/core/bdil_pkg.sv -----
// bdil_pkg: sizes, payload structs and register codes of the 3x3 dilation core.
// No dependencies; imported by binary_dilation_3x3_core.
`timescale 1ns / 1ps

package bdil_pkg;

  // Frame and pixel limits
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int PixelBits = 8;

  // Configuration port
  localparam int CfgDataW = 11;
  localparam int CfgIdxW  = 2;

  // Derived widths: column index, width value, row counter (runs to height + 1)
  localparam int ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int DimW = $clog2(MaxWidth + 1);
  localparam int RowW = $clog2(MaxHeight + 2);

  localparam logic [PixelBits-1:0] PixMax = {PixelBits{1'b1}};

  // Register reset values
  localparam logic [DimW-1:0]      ResetWidth     = DimW'(640);
  localparam logic [RowW-1:0]      ResetHeight    = RowW'(480);
  localparam logic [PixelBits-1:0] ResetThreshold = PixelBits'(127);

  // Item kind code
  localparam logic KindPixel = 1'b0;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1,
    CfgThreshold   = 2'd2
  } cfg_reg_e;

  // Input transaction
  typedef struct packed {
    logic                 kind;
    logic [PixelBits-1:0] pixel;
  } bdil_in_t;

  // Output transaction
  typedef struct packed {
    logic [PixelBits-1:0] out_pixel;
    logic                 last;
  } bdil_out_t;

  // One window column: rows above, at and below the center row (edge clamped)
  typedef struct packed {
    logic [PixelBits-1:0] top;
    logic [PixelBits-1:0] mid;
    logic [PixelBits-1:0] bot;
  } bdil_col_t;

  // Control carried with an item into the window stage
  typedef struct packed {
    logic emit;       // item produces a result
    logic last;       // result is the final pixel of the frame
    logic row_start;  // item sits at column 0
    logic top_clamp;  // center row is the first row
    logic bot_clamp;  // center row is the last row
    logic parity;     // low bit of the item's row
    logic h1_fill;    // single-row frame: preload the window with column 0
  } bdil_s1_t;

endpackage

// ----- rtl/core/bdil_ram.sv -----
// bdil_ram: generic single-port RAM, write and read at one address, read-first,
// registered read data. No dependencies.
`timescale 1ns / 1ps

module bdil_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read; a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/binary_dilation_3x3_core.sv -----
// binary_dilation_3x3_core: streaming 3x3 greyscale dilation, pixels in raster order.
// Depends on bdil_pkg, bdil_ram and assert_macros.svh.
// Input channel: one transaction per pixel (kind = pixel) and, after the frame,
// width+1 flush transactions (width if height is one); any transaction once the
// frame is complete acts as a flush; earlier flush transactions are dropped.
// Output channel: one transaction per pixel; last marks the final pixel.
// Config channel: width, height and threshold; each write restarts the frame.
// Write only while idle. Width and height of zero act as one, larger values
// saturate at the maximum. cfg_ready_o is always high.
// Result path: the result for raster position p passes the window stage and is
// registered at the output once the transaction for position p+width+1 is accepted.
// Throughput: one transaction per cycle while the output is not stalled, set by the
// two row stores, read at the column address per arrival and written per pixel.
// Reset: width 640, height 480, threshold 127, frame position zero. The row
// stores are not cleared; no entry is used before the frame writes it.
// Stall: a stalled output register holds its result; one more transaction waits
// in the window stage, after which in_ready_o drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_dilation_3x3_core
  import bdil_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bdil_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bdil_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration
  logic [DimW-1:0]      w_q, w_d, cfg_w;
  logic [RowW-1:0]      h_q, h_d, cfg_h;
  logic [PixelBits-1:0] thr_q, thr_d;
  logic                 cfg_fire, cfg_hit;

  // Frame position of the next arrival
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            real_phase, in_fire, arrive, px_wr;
  logic            col_last, h1_jump, final_pos;

  // Window stage
  logic                 s1_valid_q, s1_valid_d;
  bdil_s1_t             s1_ctl_q, s1_ctl_d;
  logic [PixelBits-1:0] s1_px_q, first_px_q;
  logic                 s1_go, s1_adv;
  logic [PixelBits-1:0] rd0, rd1, mid_px, top_raw, center;
  bdil_col_t            col_new, fill_col, right_col, win_a_q, win_b_q;
  logic [7:0]           hot_vec;
  logic                 hot;

  // Output register
  logic      out_valid_q, out_valid_d, out_load;
  bdil_out_t out_data_q;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Clamp width and height to their legal ranges
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_w = DimW'(1);
      cfg_h = RowW'(1);
    end else begin
      cfg_w = (int'(cfg_data_i) > MaxWidth) ? DimW'(MaxWidth) : DimW'(cfg_data_i);
      cfg_h = (int'(cfg_data_i) > MaxHeight) ? RowW'(MaxHeight) : RowW'(cfg_data_i);
    end
  end

  // Decode the register index
  always_comb begin
    w_d     = w_q;
    h_d     = h_q;
    thr_d   = thr_q;
    cfg_hit = 1'b0;
    if (cfg_fire) begin
      case (cfg_idx_i)
        CfgFrameWidth: begin
          w_d     = cfg_w;
          cfg_hit = 1'b1;
        end
        CfgFrameHeight: begin
          h_d     = cfg_h;
          cfg_hit = 1'b1;
        end
        CfgThreshold: begin
          thr_d   = PixelBits'(cfg_data_i);
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= ResetWidth;
      h_q   <= ResetHeight;
      thr_q <= ResetThreshold;
    end else begin
      w_q   <= w_d;
      h_q   <= h_d;
      thr_q <= thr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Arrival decode: real pixels below row height, flush rows after the frame
  // ---------------------------------------------------------------------------
  assign in_fire    = in_valid_i && in_ready_o;
  assign real_phase = row_q < h_q;
  assign arrive     = in_fire && (!real_phase || (in_data_i.kind == KindPixel));
  assign px_wr      = arrive && real_phase;
  assign col_last   = (DimW'(col_q) + DimW'(1)) == w_q;
  assign final_pos  = row_q == (h_q + RowW'(1));
  // A single-row frame skips the flush at column 0: the last pixel preloads it
  assign h1_jump    = px_wr && (h_q == RowW'(1)) && col_last;

  // Advance the arrival position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (arrive) begin
      if (final_pos) begin
        col_d = '0;
        row_d = '0;
      end else if (h1_jump) begin
        if (w_q == DimW'(1)) begin
          col_d = '0;
          row_d = RowW'(2);
        end else begin
          col_d = ColW'(1);
          row_d = RowW'(1);
        end
      end else if (col_last) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Control for the window stage; an arrival at row R builds the column for row R-1
  always_comb begin
    s1_ctl_d.emit      = (col_q != '0) ? (row_q >= RowW'(1)) : (row_q >= RowW'(2));
    s1_ctl_d.last      = final_pos;
    s1_ctl_d.row_start = col_q == '0;
    s1_ctl_d.top_clamp = row_q == RowW'(1);
    s1_ctl_d.bot_clamp = row_q == h_q;
    s1_ctl_d.parity    = row_q[0];
    s1_ctl_d.h1_fill   = h1_jump;
  end

  // ---------------------------------------------------------------------------
  // Row stores: row R goes to the store of its parity; the other holds row R-1
  // ---------------------------------------------------------------------------
  bdil_ram #(
    .Width (PixelBits),
    .Depth (MaxWidth)
  ) u_row_store_a (
    .clk_i   (clk_i),
    .we_i    (px_wr && !row_q[0]),
    .re_i    (arrive),
    .addr_i  (col_q),
    .wdata_i (in_data_i.pixel),
    .rdata_o (rd0)
  );

  bdil_ram #(
    .Width (PixelBits),
    .Depth (MaxWidth)
  ) u_row_store_b (
    .clk_i   (clk_i),
    .we_i    (px_wr && row_q[0]),
    .re_i    (arrive),
    .addr_i  (col_q),
    .wdata_i (in_data_i.pixel),
    .rdata_o (rd1)
  );

  // ---------------------------------------------------------------------------
  // Window stage
  // ---------------------------------------------------------------------------
  assign s1_go      = !s1_ctl_q.emit || !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && s1_go;
  assign in_ready_o = !s1_valid_q || s1_go;
  assign s1_valid_d = arrive || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Capture item payload; keep the row's first pixel for single-row frames
  always_ff @(posedge clk_i) begin
    if (arrive) begin
      s1_ctl_q <= s1_ctl_d;
      s1_px_q  <= in_data_i.pixel;
    end
    if (px_wr && (col_q == '0)) begin
      first_px_q <= in_data_i.pixel;
    end
  end

  // Build the new column with vertical clamping
  always_comb begin
    mid_px      = s1_ctl_q.parity ? rd0 : rd1;
    top_raw     = s1_ctl_q.parity ? rd1 : rd0;
    col_new.top = s1_ctl_q.top_clamp ? mid_px : top_raw;
    col_new.mid = mid_px;
    col_new.bot = s1_ctl_q.bot_clamp ? mid_px : s1_px_q;
    fill_col    = '{top: first_px_q, mid: first_px_q, bot: first_px_q};
    // At a row start the result is the previous row's last pixel: clamp right
    right_col   = s1_ctl_q.row_start ? win_b_q : col_new;
  end

  // Compare the eight neighbors against the threshold
  always_comb begin
    center     = win_b_q.mid;
    hot_vec[0] = win_a_q.top > thr_q;
    hot_vec[1] = win_a_q.mid > thr_q;
    hot_vec[2] = win_a_q.bot > thr_q;
    hot_vec[3] = win_b_q.top > thr_q;
    hot_vec[4] = win_b_q.bot > thr_q;
    hot_vec[5] = right_col.top > thr_q;
    hot_vec[6] = right_col.mid > thr_q;
    hot_vec[7] = right_col.bot > thr_q;
    hot        = |hot_vec;
  end

  // Shift the window, or refill it at a row start
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_ctl_q.h1_fill) begin
        win_a_q <= fill_col;
        win_b_q <= fill_col;
      end else if (s1_ctl_q.row_start) begin
        win_a_q <= col_new;
        win_b_q <= col_new;
      end else begin
        win_a_q <= win_b_q;
        win_b_q <= col_new;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  assign out_load    = s1_adv && s1_ctl_q.emit;
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the dilated pixel
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.out_pixel <= ((center < thr_q) && hot) ? PixMax : center;
      out_data_q.last      <= s1_ctl_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BDIL_ASSERT_NEVER(out_no_overwrite, out_valid_q && !out_ready_i && out_load)
  `BDIL_ASSERT(col_in_frame, DimW'(col_q) < w_q)
  `BDIL_ASSERT(row_in_range, row_q <= (h_q + RowW'(1)))
  `BDIL_ASSERT(last_emits, s1_valid_q && s1_ctl_q.last |-> s1_ctl_q.emit)
  `BDIL_ASSERT(frame_restart, arrive && final_pos |=> (row_q == '0) && (col_q == '0))

endmodule
